// ===== sv/bei_pkg.sv =====
// ---------------------------------------------------------------------------
// bei_pkg
// Shared types, codes and defaults for the breakpoint envelope interpolator.
// ---------------------------------------------------------------------------
package bei_pkg;

  localparam int MaxPointsDef = 16;
  localparam int CosDepthDef  = 256;

  // divider: 48-bit dividend, 32-bit divisor
  localparam int DivW = 48;

  localparam logic [1:0] ST_VALUE    = 2'd0;
  localparam logic [1:0] ST_IDLE     = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [2:0] CRV_LINEAR   = 3'd0;
  localparam logic [2:0] CRV_SQUARE   = 3'd1;
  localparam logic [2:0] CRV_SQRT     = 3'd2;
  localparam logic [2:0] CRV_COSINE   = 3'd3;
  localparam logic [2:0] CRV_STEP     = 3'd4;
  localparam logic [2:0] CRV_SAW      = 3'd5;
  localparam logic [2:0] CRV_TRIANGLE = 3'd6;

  localparam logic [1:0] REG_RUN   = 2'd0;
  localparam logic [1:0] REG_LOOP  = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;

  localparam logic [63:0] PiQ30 = 64'd3373259426;

  typedef struct packed {
    logic [2:0]         crv;
    logic signed [31:0] val;
    logic [31:0]        tm;
  } bp_entry_t;

endpackage

// ===== sv/bei_ram.sv =====
// ---------------------------------------------------------------------------
// bei_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module bei_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [0:Depth-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bei_div.sv =====
// ---------------------------------------------------------------------------
// bei_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bei_div import bei_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [31:0]     divisor,
  output logic            done,
  output logic [DivW-1:0] quotient,
  output logic [31:0]     remainder
);

  localparam int CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DivW-1:0] quo_r, quo_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     dvs_r, dvs_nxt;
  logic [32:0]     shl;
  logic [33:0]     trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    shl      = {rem_r, quo_r[DivW-1]};
    trial    = {1'b0, shl} - {2'b00, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CntW'(DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shl[31:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/bei_sqrt.sv =====
// ---------------------------------------------------------------------------
// bei_sqrt
// Integer square root of a 33-bit value, one result bit per cycle (17 steps).
// ---------------------------------------------------------------------------
module bei_sqrt import bei_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] radicand,
  output logic        done,
  output logic [16:0] root
);

  logic [33:0] x_r, x_nxt;
  logic [33:0] r_r, r_nxt;
  logic [33:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = r_r + bit_r;
    if (start) begin
      x_nxt    = {1'b0, radicand};
      r_nxt    = '0;
      bit_nxt  = 34'd1 << 32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[16:0];

endmodule

// ===== sv/bei_hc.sv =====
// ---------------------------------------------------------------------------
// bei_hc
// Raised-cosine constant table, sin^2 in Q16, Taylor series worked out at
// elaboration. Returns the entry at idx and the one after it (idx itself at Depth).
// ---------------------------------------------------------------------------
module bei_hc import bei_pkg::*; #(
  parameter int Depth = CosDepthDef
) (
  input  logic [$clog2(Depth+1)-1:0] idx,
  output logic [16:0]                lo,
  output logic [16:0]                hi
);

  localparam int HW = $clog2(Depth + 1);

  logic [16:0] tab [0:Depth];

  for (genvar k = 0; k <= Depth; k++) begin : g_tab
    localparam logic [63:0] X   = (64'(k) * PiQ30 + 64'(Depth)) / 64'(2 * Depth);
    localparam logic [63:0] X2  = (X * X) >> 30;
    localparam logic [63:0] T1  = ((X * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd210;
    localparam logic [63:0] T8  = ((T7 * X2) >> 30) / 64'd272;
    localparam logic [63:0] T9  = ((T8 * X2) >> 30) / 64'd342;
    localparam logic [63:0] T10 = ((T9 * X2) >> 30) / 64'd420;
    localparam logic [63:0] T11 = ((T10 * X2) >> 30) / 64'd506;
    localparam logic [63:0] T12 = ((T11 * X2) >> 30) / 64'd600;
    localparam logic [63:0] S   = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                                  + T10 - T11 + T12;
    localparam logic [63:0] H   = (S * S + (64'd1 << 43)) >> 44;
    localparam logic [63:0] HC  = (k == 0) ? 64'd0 :
                                  (k == Depth) ? 64'd65536 :
                                  (H > 64'd65536) ? 64'd65536 : H;
    assign tab[k] = HC[16:0];
  end

  assign lo = tab[idx];
  assign hi = (idx == HW'(Depth)) ? tab[idx] : tab[idx + 1'b1];

endmodule

// ===== sv/breakpoint_envelope_interpolator.sv =====
// ---------------------------------------------------------------------------
// breakpoint_envelope_interpolator
// Breakpoint table in RAM with sorted insert and interpolating time query.
// ---------------------------------------------------------------------------
// Input words (in_*): in_tuser selects insert (0) or query (1). An insert
// places the point after all points of equal or smaller time and answers
// status inserted, or table full. A query answers the envelope value at
// in time_now, or status inactive/empty when disabled or without points.
// Config words (cfg_*) set run, loop and start time; write them while idle.
// One word at a time: in_tready is high only in the idle state. Work per word:
//   insert: table RAM read-compare-write, shifting later points up one slot
//   query:  segment scan, a loop modulo (when looping) and a fraction divide,
//           both on the shared bit-serial divider, plus the bit-serial sqrt
//           unit for the sqrt curve.
// The result sits in an output register; a stalled receiver holds it and the
// next word may already be accepted and worked, finishing once it drains.
// Reset empties the table (count to zero) and clears all config registers;
// the RAM itself is not cleared.
// ---------------------------------------------------------------------------
module breakpoint_envelope_interpolator import bei_pkg::*; #(
  parameter int MAX_POINTS      = MaxPointsDef,
  parameter int COS_TABLE_DEPTH = CosDepthDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] point_time_ms, [63:32] point_value, [66:64] point_curve,
  // [98:67] time_now, [103:99] zero
  input  logic [103:0] in_tdata,
  // [0] func
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] env_value
  output logic [31:0]  out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int HW   = $clog2(COS_TABLE_DEPTH + 1);
  localparam int PW   = 17 + HW;
  localparam int EW   = $bits(bp_entry_t);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_CMP = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_Q_LAST  = 4'd3;
  localparam logic [3:0] S_Q_MOD   = 4'd4;
  localparam logic [3:0] S_Q_FIRST = 4'd5;
  localparam logic [3:0] S_Q_SCAN  = 4'd6;
  localparam logic [3:0] S_Q_DIV   = 4'd7;
  localparam logic [3:0] S_Q_WGT   = 4'd8;
  localparam logic [3:0] S_Q_SQRT  = 4'd9;
  localparam logic [3:0] S_Q_COS   = 4'd10;
  localparam logic [3:0] S_Q_COS2  = 4'd11;
  localparam logic [3:0] S_Q_MUL   = 4'd12;
  localparam logic [3:0] S_Q_ADD   = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  bp_entry_t           new_r, new_nxt;
  bp_entry_t           prev_r, prev_nxt;
  bp_entry_t           seg_r, seg_nxt;
  logic [31:0]         elapsed_r, elapsed_nxt;
  logic [31:0]         tlast_r, tlast_nxt;
  logic signed [31:0]  vlast_r, vlast_nxt;
  logic [16:0]         f_r, f_nxt;
  logic [16:0]         w_r, w_nxt;
  logic [HW-1:0]       hidx_r, hidx_nxt;
  logic [15:0]         hfr_r, hfr_nxt;
  logic signed [50:0]  prod_r, prod_nxt;
  logic signed [31:0]  res_val_r, res_val_nxt;
  logic [1:0]          res_stat_r, res_stat_nxt;
  logic                run_r, loop_r;
  logic [31:0]         start_r;
  logic                out_valid_r;
  logic [31:0]         out_data_r;
  logic [1:0]          out_stat_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  bp_entry_t           ram_wdata, rd;
  logic [EW-1:0]       ram_rdata;

  logic                div_start, div_done;
  logic [DivW-1:0]     div_dvd, div_quo;
  logic [31:0]         div_dvs, div_rem;
  logic                sq_start, sq_done;
  logic [16:0]         sq_root;
  logic [16:0]         hc_lo, hc_hi;

  logic                in_acc, out_load;
  logic [31:0]         seg_len;
  logic [33:0]         sq_prod;
  logic [16:0]         cos_u;
  logic [PW-1:0]       cos_pos;
  logic signed [17:0]  hc_diff;
  logic signed [35:0]  hc_prod;
  logic signed [32:0]  v_diff;
  logic signed [35:0]  v_sum;

  assign rd = bp_entry_t'(ram_rdata);

  bei_ram #(.Width(EW), .Depth(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bei_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  bei_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({div_quo[16:0], 16'h0000}),
    .done     (sq_done),
    .root     (sq_root)
  );

  bei_hc #(.Depth(COS_TABLE_DEPTH)) u_hc (
    .idx (hidx_r),
    .lo  (hc_lo),
    .hi  (hc_hi)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    j_nxt        = j_r;
    new_nxt      = new_r;
    prev_nxt     = prev_r;
    seg_nxt      = seg_r;
    elapsed_nxt  = elapsed_r;
    tlast_nxt    = tlast_r;
    vlast_nxt    = vlast_r;
    f_nxt        = f_r;
    w_nxt        = w_r;
    hidx_nxt     = hidx_r;
    hfr_nxt      = hfr_r;
    prod_nxt     = prod_r;
    res_val_nxt  = res_val_r;
    res_stat_nxt = res_stat_r;
    ram_we       = 1'b0;
    ram_waddr    = AW'(j_r);
    ram_wdata    = new_r;
    ram_raddr    = AW'(count_r - 1'b1);
    div_start    = 1'b0;
    div_dvd      = {16'h0000, elapsed_r};
    div_dvs      = tlast_r;
    sq_start     = 1'b0;
    seg_len      = rd.tm - prev_r.tm;
    sq_prod      = f_r * f_r;
    cos_u        = (f_r <= 17'd32768) ? {f_r[15:0], 1'b0} : 17'(18'(2) * (18'd65536 - f_r));
    cos_pos      = PW'(cos_u) * PW'(COS_TABLE_DEPTH);
    hc_diff      = $signed({1'b0, hc_hi}) - $signed({1'b0, hc_lo});
    hc_prod      = hc_diff * $signed({1'b0, hfr_r});
    v_diff       = 33'(seg_r.val) - 33'(prev_r.val);
    v_sum        = 36'(prev_r.val) + 36'(prod_r >>> 16);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_val_nxt = '0;
          new_nxt.tm  = in_tdata[31:0];
          new_nxt.val = in_tdata[63:32];
          new_nxt.crv = in_tdata[66:64];
          j_nxt       = count_r;
          if (!in_tuser) begin
            if (count_r == CW'(MAX_POINTS)) begin
              res_stat_nxt = ST_FULL;
              state_nxt    = S_DONE;
            end else if (count_r == '0) begin
              state_nxt = S_INS_WR;
            end else begin
              state_nxt = S_INS_CMP;
            end
          end else if (!run_r || count_r == '0) begin
            res_stat_nxt = ST_IDLE;
            state_nxt    = S_DONE;
          end else begin
            elapsed_nxt = in_tdata[98:67] - start_r;
            state_nxt   = S_Q_LAST;
          end
        end
      end
      S_INS_CMP: begin
        // shift later points up one slot until the insert position
        if (rd.tm > new_r.tm) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          ram_raddr = AW'(j_r - CW'(2));
          j_nxt     = j_r - 1'b1;
          if (j_r == CW'(1)) begin
            state_nxt = S_INS_WR;
          end
        end else begin
          ram_we       = 1'b1;
          count_nxt    = count_r + 1'b1;
          res_stat_nxt = ST_INSERTED;
          state_nxt    = S_DONE;
        end
      end
      S_INS_WR: begin
        ram_we       = 1'b1;
        count_nxt    = count_r + 1'b1;
        res_stat_nxt = ST_INSERTED;
        state_nxt    = S_DONE;
      end
      S_Q_LAST: begin
        tlast_nxt = rd.tm;
        vlast_nxt = rd.val;
        ram_raddr = '0;
        if (loop_r && rd.tm != 32'd0) begin
          div_start = 1'b1;
          div_dvs   = rd.tm;
          state_nxt = S_Q_MOD;
        end else begin
          state_nxt = S_Q_FIRST;
        end
      end
      S_Q_MOD: begin
        ram_raddr = '0;
        if (div_done) begin
          elapsed_nxt = div_rem;
          state_nxt   = S_Q_FIRST;
        end
      end
      S_Q_FIRST: begin
        res_stat_nxt = ST_VALUE;
        ram_raddr    = AW'(1);
        prev_nxt     = rd;
        j_nxt        = CW'(1);
        if (elapsed_r <= rd.tm) begin
          res_val_nxt = rd.val;
          state_nxt   = S_DONE;
        end else if (elapsed_r >= tlast_r) begin
          res_val_nxt = loop_r ? rd.val : vlast_r;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_Q_SCAN;
        end
      end
      S_Q_SCAN: begin
        // table is sorted: first end point at or past elapsed closes the segment
        ram_raddr = AW'(j_r + 1'b1);
        if (elapsed_r <= rd.tm) begin
          seg_nxt = rd;
          if (seg_len == 32'd0) begin
            res_val_nxt = prev_r.val;
            state_nxt   = S_DONE;
          end else begin
            div_start = 1'b1;
            div_dvd   = {elapsed_r - prev_r.tm, 16'h0000};
            div_dvs   = seg_len;
            state_nxt = S_Q_DIV;
          end
        end else begin
          prev_nxt = rd;
          j_nxt    = j_r + 1'b1;
        end
      end
      S_Q_DIV: begin
        if (div_done) begin
          f_nxt = div_quo[16:0];
          case (prev_r.crv)
            CRV_STEP: begin
              res_val_nxt = (div_quo[16:0] < 17'd32768) ? prev_r.val : seg_r.val;
              state_nxt   = S_DONE;
            end
            CRV_SQRT: begin
              sq_start  = 1'b1;
              state_nxt = S_Q_SQRT;
            end
            CRV_COSINE: state_nxt = S_Q_COS;
            default:    state_nxt = S_Q_WGT;
          endcase
        end
      end
      S_Q_WGT: begin
        case (prev_r.crv)
          CRV_SQUARE: w_nxt = sq_prod[32:16];
          CRV_TRIANGLE: begin
            w_nxt = (f_r < 17'd32768) ? {f_r[15:0], 1'b0}
                                      : 17'(18'(2) * (18'd65536 - f_r));
          end
          default: w_nxt = f_r;
        endcase
        state_nxt = S_Q_MUL;
      end
      S_Q_SQRT: begin
        if (sq_done) begin
          w_nxt     = sq_root;
          state_nxt = S_Q_MUL;
        end
      end
      S_Q_COS: begin
        hidx_nxt  = cos_pos[16 +: HW];
        hfr_nxt   = cos_pos[15:0];
        state_nxt = S_Q_COS2;
      end
      S_Q_COS2: begin
        if (hidx_r >= HW'(COS_TABLE_DEPTH)) begin
          w_nxt = 17'd65536;
        end else begin
          w_nxt = 17'($signed({1'b0, hc_lo}) + 18'(hc_prod >>> 16));
        end
        state_nxt = S_Q_MUL;
      end
      S_Q_MUL: begin
        prod_nxt  = $signed({1'b0, w_r}) * v_diff;
        state_nxt = S_Q_ADD;
      end
      S_Q_ADD: begin
        if (v_sum > 36'sd2147483647) begin
          res_val_nxt = 32'h7FFF_FFFF;
        end else if (v_sum < -36'sd2147483648) begin
          res_val_nxt = 32'h8000_0000;
        end else begin
          res_val_nxt = v_sum[31:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      run_r       <= 1'b0;
      loop_r      <= 1'b0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RUN:   run_r   <= cfg_data[0];
          REG_LOOP:  loop_r  <= cfg_data[0];
          REG_START: start_r <= cfg_data;
          default:   ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    j_r        <= j_nxt;
    new_r      <= new_nxt;
    prev_r     <= prev_nxt;
    seg_r      <= seg_nxt;
    elapsed_r  <= elapsed_nxt;
    tlast_r    <= tlast_nxt;
    vlast_r    <= vlast_nxt;
    f_r        <= f_nxt;
    w_r        <= w_nxt;
    hidx_r     <= hidx_nxt;
    hfr_r      <= hfr_nxt;
    prod_r     <= prod_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_data_r <= res_val_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

// ===== sv/bei_chk.sv =====
// ---------------------------------------------------------------------------
// bei_chk
// Port-level checks for the breakpoint envelope interpolator, bound to top.
// ---------------------------------------------------------------------------
module bei_chk import bei_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // held result must not drop while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // only a value word carries a nonzero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_VALUE |-> out_tdata == 32'd0)
    else $error("nonzero value on status word");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind breakpoint_envelope_interpolator bei_chk u_bei_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
